### design/rgblab_pkg.sv
// Constants shared by the RGB to L*a*b* pipeline: matrix, white point and divider constants.
package rgblab_pkg;

  localparam int NCH = 3;
  localparam int QF = 20;          // fraction bits of q and f
  localparam int QW = 22;          // width of q
  localparam int FW = 21;          // width of f
  localparam int EST_SH = 40;      // scale of the quotient estimate
  localparam int CR_STEPS = 21;    // one cube-root bit per stage

  typedef logic [23:0] coef_t;
  typedef logic [63:0] wide_t;
  typedef logic [QW-1:0] q_t;
  typedef logic [FW-1:0] f_t;

  // Matrix in units of 1e-7 and white point in units of 1e-6.
  localparam coef_t MAT [NCH][NCH] = '{
    '{24'd4124240, 24'd3575790, 24'd1804640},
    '{24'd2126560, 24'd7151580, 24'd721856},
    '{24'd193324,  24'd1191930, 24'd9504440}
  };

  // q = round(sum * CMUL / DEN); the common factor 2^7 is already cancelled.
  localparam longint unsigned CMUL = 64'd1961 << 14;
  localparam longint unsigned DEN0 = 64'd950467 * 64'd78125;
  localparam longint unsigned DEN1 = 64'd1000000 * 64'd78125;
  localparam longint unsigned DEN2 = 64'd1088969 * 64'd78125;
  localparam wide_t DEN [NCH] = '{DEN0, DEN1, DEN2};

  // Per-coefficient estimate factors, floor(m * CMUL * 2^EST_SH / DEN).
  localparam wide_t EST [NCH][NCH] = '{
    '{64'(((128'(64'd4124240) * CMUL) << EST_SH) / DEN0),
      64'(((128'(64'd3575790) * CMUL) << EST_SH) / DEN0),
      64'(((128'(64'd1804640) * CMUL) << EST_SH) / DEN0)},
    '{64'(((128'(64'd2126560) * CMUL) << EST_SH) / DEN1),
      64'(((128'(64'd7151580) * CMUL) << EST_SH) / DEN1),
      64'(((128'(64'd721856) * CMUL) << EST_SH) / DEN1)},
    '{64'(((128'(64'd193324) * CMUL) << EST_SH) / DEN2),
      64'(((128'(64'd1191930) * CMUL) << EST_SH) / DEN2),
      64'(((128'(64'd9504440) * CMUL) << EST_SH) / DEN2)}
  };

  // Companding knee: q * 10^6 > 8856 * 2^20 is the same as q > KNEE_Q.
  localparam q_t KNEE_Q = QW'((64'd8856 << QF) / 64'd1000000);
  localparam f_t LIN_OFFSET = FW'(((64'd137931 << QF) + 64'd500000) / 64'd1000000);

  // Exact division by 1000 for values below 2^LIN_XW.
  localparam int LIN_XW = 27;
  localparam int DIV_SH = 37;
  localparam longint unsigned DIV_M = ((64'd1 << DIV_SH) + 64'd999) / 64'd1000;

endpackage

### design/rgb_to_lab_converter.sv
// Pipelined RGB to CIE L*a*b* (D65) converter.
// Stages in order: channel sums and estimate, partial products, exact quotient, cube root, Lab terms, rounding.
// Throughput: one pixel per cycle; each stage holds its item until the next one frees.
// The 21-step cube root, one result bit per stage, sets the depth.
// Reset clears every stage valid bit; payload registers are not reset.
module rgb_to_lab_converter #(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] lightness,
  output logic signed [15:0] green_red_axis,
  output logic signed [15:0] blue_yellow_axis
);
  import rgblab_pkg::*;

  localparam int NST = 26;
  localparam int ST_F = 24;
  localparam int ST_O = 25;
  localparam int RSH = QF - OUT_FRAC_BITS;
  localparam logic signed [39:0] RND = 40'sd1 <<< (RSH - 1);
  localparam logic signed [39:0] L_MAX = 40'sd100 <<< OUT_FRAC_BITS;

  logic [NST-1:0] v;
  logic [NST-1:0] adv;

  // Stage 0: channel sums and quotient estimate.
  logic [31:0] sum0 [NCH];
  q_t          qe0 [NCH];
  // Stage 1: doubled numerator and partial products of qe * DEN.
  wide_t       t2 [NCH];
  logic [41:0] pl [NCH];
  logic [38:0] ph [NCH];
  q_t          qe1 [NCH];
  // Stage 2: exact rounded quotient.
  q_t          q2 [NCH];
  // Cube-root stages.
  wide_t       cr_n [CR_STEPS][NCH];
  logic [20:0] cr_r [CR_STEPS][NCH];
  logic [41:0] cr_r2 [CR_STEPS][NCH];
  wide_t       cr_r3 [CR_STEPS][NCH];
  logic        knee [CR_STEPS][NCH];
  logic [LIN_XW-1:0] lx [NCH];
  f_t          lin [CR_STEPS][NCH];
  // Final stages.
  logic signed [39:0] lraw, araw, braw;

  logic [20:0] r_next [CR_STEPS][NCH];
  logic [41:0] r2_next [CR_STEPS][NCH];
  wide_t       r3_next [CR_STEPS][NCH];

  always_comb begin
    adv[ST_O] = !v[ST_O] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];
  assign out_valid = v[ST_O];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // One cube-root bit per stage, with r^2 and r^3 kept incrementally.
  always_comb begin
    logic [20:0] r_in;
    logic [41:0] r2_in;
    wide_t       r3_in, n_in, c3;
    for (int k = 0; k < CR_STEPS; k++) begin
      for (int c = 0; c < NCH; c++) begin
        if (k == 0) begin
          r_in = '0;
          r2_in = '0;
          r3_in = '0;
          n_in = 64'(q2[c]) << 40;
        end else begin
          r_in = cr_r[k-1][c];
          r2_in = cr_r2[k-1][c];
          r3_in = cr_r3[k-1][c];
          n_in = cr_n[k-1][c];
        end
        c3 = r3_in + 3 * (64'(r2_in) << (20 - k)) + 3 * (64'(r_in) << (2 * (20 - k)))
             + (64'd1 << (3 * (20 - k)));
        if (c3 <= n_in) begin
          r_next[k][c] = r_in | (21'd1 << (20 - k));
          r2_next[k][c] = r2_in + (42'(r_in) << (21 - k)) + (42'd1 << (2 * (20 - k)));
          r3_next[k][c] = c3;
        end else begin
          r_next[k][c] = r_in;
          r2_next[k][c] = r2_in;
          r3_next[k][c] = r3_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [7:0]  ch [NCH];
    wide_t       est;
    wide_t       rem;
    logic signed [39:0] fx, fy, fz;
    logic signed [39:0] lr, ar, br;
    ch[0] = red;
    ch[1] = green;
    ch[2] = blue;

    if (adv[0]) begin
      for (int c = 0; c < NCH; c++) begin
        sum0[c] <= 32'(ch[0]) * 32'(MAT[c][0]) + 32'(ch[1]) * 32'(MAT[c][1])
                   + 32'(ch[2]) * 32'(MAT[c][2]);
        est = 64'(ch[0]) * EST[c][0] + 64'(ch[1]) * EST[c][1] + 64'(ch[2]) * EST[c][2]
              + (64'd1 << (EST_SH - 1));
        qe0[c] <= QW'(est >> EST_SH);
      end
    end

    if (adv[1]) begin
      for (int c = 0; c < NCH; c++) begin
        t2[c] <= ((64'(sum0[c]) * 64'd1961) << 15) + DEN[c];
        pl[c] <= 42'(qe0[c]) * 42'(DEN[c][19:0]);
        ph[c] <= 39'(qe0[c]) * 39'(DEN[c] >> 20);
        qe1[c] <= qe0[c];
      end
    end

    // The estimate is the rounded quotient or one below it.
    if (adv[2]) begin
      for (int c = 0; c < NCH; c++) begin
        rem = t2[c] - (((64'(ph[c]) << 20) + 64'(pl[c])) << 1);
        q2[c] <= (rem >= (DEN[c] << 1)) ? qe1[c] + 1'b1 : qe1[c];
      end
    end

    for (int k = 0; k < CR_STEPS; k++) begin
      if (adv[3+k]) begin
        for (int c = 0; c < NCH; c++) begin
          cr_r[k][c] <= r_next[k][c];
          cr_r2[k][c] <= r2_next[k][c];
          cr_r3[k][c] <= r3_next[k][c];
          if (k == 0) begin
            cr_n[k][c] <= 64'(q2[c]) << 40;
            knee[k][c] <= q2[c] > KNEE_Q;
            lx[c] <= LIN_XW'(64'(q2[c]) * 64'd7787 + 64'd500);
          end else begin
            cr_n[k][c] <= cr_n[k-1][c];
            knee[k][c] <= knee[k-1][c];
            if (k == 1) begin
              lin[k][c] <= FW'((64'(lx[c]) * DIV_M) >> DIV_SH) + LIN_OFFSET;
            end else begin
              lin[k][c] <= lin[k-1][c];
            end
          end
        end
      end
    end

    if (adv[ST_F]) begin
      fx = 40'(knee[CR_STEPS-1][0] ? cr_r[CR_STEPS-1][0] : lin[CR_STEPS-1][0]);
      fy = 40'(knee[CR_STEPS-1][1] ? cr_r[CR_STEPS-1][1] : lin[CR_STEPS-1][1]);
      fz = 40'(knee[CR_STEPS-1][2] ? cr_r[CR_STEPS-1][2] : lin[CR_STEPS-1][2]);
      lraw <= 40'sd116 * fy - (40'sd16 <<< QF);
      araw <= 40'sd500 * (fx - fy);
      braw <= 40'sd200 * (fy - fz);
    end

    // Round half up by an arithmetic shift, then saturate.
    if (adv[ST_O]) begin
      lr = (lraw + RND) >>> RSH;
      ar = (araw + RND) >>> RSH;
      br = (braw + RND) >>> RSH;
      if (lr < 0) lr = '0;
      else if (lr > L_MAX) lr = L_MAX;
      if (ar < -40'sd32768) ar = -40'sd32768;
      else if (ar > 40'sd32767) ar = 40'sd32767;
      if (br < -40'sd32768) br = -40'sd32768;
      else if (br > 40'sd32767) br = 40'sd32767;
      lightness <= lr[14:0];
      green_red_axis <= ar[15:0];
      blue_yellow_axis <= br[15:0];
    end
  end

endmodule

### dv/rgb_to_lab_checker.sv
// Checker for the RGB to L*a*b* converter: predicts each pixel's result and compares it.
module rgb_to_lab_checker #(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [14:0] lightness,
  input  logic signed [15:0] green_red_axis,
  input  logic signed [15:0] blue_yellow_axis,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [14:0] l;
    logic [15:0] a;
    logic [15:0] b;
  } lab_t;

  lab_t lab_queue[$];

  function automatic longint unsigned cube_root(longint unsigned n);
    longint unsigned r, c;
    r = 0;
    for (int bit_idx = 20; bit_idx >= 0; bit_idx--) begin
      c = r | (64'd1 << bit_idx);
      if (c * c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint unsigned compand(longint unsigned q);
    longint unsigned lin_off;
    lin_off = ((64'd137931 << 20) + 64'd500000) / 64'd1000000;
    if (q * 64'd1000000 > (64'd8856 << 20)) return cube_root(q << 40);
    return (q * 64'd7787 + 64'd500) / 64'd1000 + lin_off;
  endfunction

  function automatic longint to_out_frac(longint v);
    int s;
    longint u;
    s = 20 - OUT_FRAC_BITS;
    u = v + (64'sd1 << (s - 1));
    if (u >= 0) return u >>> s;
    return -(((-u) + ((64'sd1 << s) - 1)) >>> s);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic lab_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] bl);
    longint unsigned m[3][3];
    longint unsigned w[3];
    longint unsigned ch[3];
    longint unsigned sum, den, q;
    longint f[3];
    longint lv, av, bv;
    lab_t res;
    m = '{'{64'd4124240, 64'd3575790, 64'd1804640},
          '{64'd2126560, 64'd7151580, 64'd721856},
          '{64'd193324, 64'd1191930, 64'd9504440}};
    w = '{64'd950467, 64'd1000000, 64'd1088969};
    ch = '{64'(r), 64'(g), 64'(bl)};
    for (int i = 0; i < 3; i++) begin
      sum = ch[0] * m[i][0] + ch[1] * m[i][1] + ch[2] * m[i][2];
      den = w[i] * 64'd10000000;
      q = (sum * 64'd3922) << 20;
      q = (q + den / 2) / den;
      f[i] = longint'(compand(q));
    end
    lv = clip(to_out_frac(116 * f[1] - (64'sd16 <<< 20)), 0, 64'sd100 <<< OUT_FRAC_BITS);
    av = clip(to_out_frac(500 * (f[0] - f[1])), -32768, 32767);
    bv = clip(to_out_frac(200 * (f[1] - f[2])), -32768, 32767);
    res.l = lv[14:0];
    res.a = av[15:0];
    res.b = bv[15:0];
    return res;
  endfunction

  always @(posedge clk) begin
    lab_t want;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) lab_queue = {lab_queue, convert_pixel(red, green, blue)};
      if (out_valid && !out_stall) begin
        if (lab_queue.size() == 0) begin
          $error("unexpected result transfer");
          errs++;
        end else begin
          want = lab_queue.pop_front();
          if (lightness !== want.l) begin
            $error("lightness: expected %0d, got %0d", want.l, lightness);
            errs++;
          end
          if (green_red_axis !== want.a) begin
            $error("green_red_axis: expected %0d, got %0d", $signed(want.a), green_red_axis);
            errs++;
          end
          if (blue_yellow_axis !== want.b) begin
            $error("blue_yellow_axis: expected %0d, got %0d", $signed(want.b),
                   blue_yellow_axis);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= lab_queue.size();
    end
  end
endmodule

### dv/testbench.sv
// Top of the converter testbench: clock, reset, pixel stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 26;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] red = '0, green = '0, blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [14:0] lightness;
  logic signed [15:0] green_red_axis, blue_yellow_axis;
  int fail_count, pending;
  int send_idle_pct = 0, recv_stall_pct = 0;
  longint cycle_count = 0;
  int pixels_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_to_lab_converter u_dut (.*);
  rgb_to_lab_checker u_check (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL rgb_to_lab_converter");
      $finish;
    end
  end

  // Presents one pixel, after an optional idle gap, and holds it until its transfer.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic send_random(int count);
    logic [7:0] c[3];
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(5))
          0: c[k] = 8'd0;
          1: c[k] = 8'd255;
          2: c[k] = 8'($urandom_range(8));
          default: c[k] = 8'($urandom);
        endcase
      end
      send_pixel(c[0], c[1], c[2]);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Corners, pure primaries, grays and the dark linear region below the knee.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd2, 8'd2, 8'd2);
    send_pixel(8'd3, 8'd3, 8'd3);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd170, 8'd85, 8'd85);
    send_pixel(8'd85, 8'd170, 8'd170);
    // Hold off until the pipeline is empty.
    drain();
    send_random(450);
    send_idle_pct = 50;
    send_random(450);
    send_idle_pct = 0;
    recv_stall_pct = 50;
    send_random(450);
    send_idle_pct = 24;
    recv_stall_pct = 24;
    send_random(450);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(60);
    drain();
    repeat (LATENCY + 4) @(posedge clk);
    $display("Converted %0d pixels: corners, primaries, grays, dark linear-branch values,",
             pixels_sent);
    $display("and random pixels under sender gaps and receiver stalls.");
    if (fail_count == 0) begin
      $display("PASS rgb_to_lab_converter");
    end else begin
      $display("FAIL rgb_to_lab_converter");
    end
    $finish;
  end
endmodule
